### rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared assertion forms for the cartridge bank controller checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbc assertion failed");

// Next-cycle implication, held off during reset.
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbc assertion failed");

`endif

### rtl/core/cbc_pkg.sv
// ============================================================================
// cbc_pkg
// Types and constants of the cartridge bank controller.
// ============================================================================
package cbc_pkg;

    // Result source codes
    typedef enum logic [2:0] {
        SRC_ROM    = 3'd0,
        SRC_BOOT   = 3'd1,
        SRC_RAM    = 3'd2,
        SRC_RAMOFF = 3'd3,
        SRC_NONE   = 3'd4
    } t_source;

    // Access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BANKING_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_EN    = 2'd2;

    // Address regions, by address[15:13]
    localparam logic [2:0] REG_RAM_EN    = 3'b000;
    localparam logic [2:0] REG_BANK_LOW  = 3'b001;
    localparam logic [2:0] REG_BANK_HIGH = 3'b010;
    localparam logic [2:0] REG_BANK_MODE = 3'b011;
    localparam logic [2:0] REG_CART_RAM  = 3'b101;

    // Address regions for reads, by address[15:14]
    localparam logic [1:0] RD_FIXED_ROM  = 2'b00;
    localparam logic [1:0] RD_SWITCH_ROM = 2'b01;

    localparam logic [3:0]  RAM_EN_KEY   = 4'hA;
    localparam logic [15:0] BOOT_EXIT    = 16'h0100;
    localparam logic [7:0]  RAMOFF_DATA  = 8'hFF;
    localparam int unsigned BOOT_AW      = 8;
    localparam int unsigned RAM_IDX_MAX_W = 15;
    localparam int unsigned ROM_AW       = 21;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_cmd;

    typedef struct packed {
        t_source            source;
        logic [ROM_AW-1:0]  rom_address;
        logic [7:0]         read_data;
    } t_res;

    // Cartridge RAM access request
    typedef struct packed {
        logic                     re;
        logic                     we;
        logic [RAM_IDX_MAX_W-1:0] index;
        logic [7:0]               wdata;
    } t_ram_req;

endpackage

### rtl/core/cartridge_bank_controller.sv
// ============================================================================
// cartridge_bank_controller
// Bank controller for a game cartridge: bank registers, address mapping,
// boot ROM overlay and banked cartridge RAM.
// ============================================================================
// The result strobe comes in the cycle after the access is taken.
// Throughput: one access per cycle; busy stays low, so start may stay high.
// Reset (synchronous, active low): bank registers cleared, boot overlay
// armed, configuration to its defaults; cartridge RAM is not cleared.
module cartridge_bank_controller #(
    parameter int unsigned RAM_BYTES     = 32768,
    parameter int unsigned ROM_ADDR_BITS = 21
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Access command
    input  logic                            start,
    output logic                            busy,
    input  cbc_pkg::t_cmd                   i_cmd,
    // Result
    output logic                            o_res_valid,
    output cbc_pkg::t_res                   o_res,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [cbc_pkg::ROM_AW-1:0] ROM_MASK =
        cbc_pkg::ROM_AW'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    // Configuration
    logic       r_banking_en;
    logic [2:0] r_rom_size;
    logic       r_boot_en;

    // Bank state
    logic       r_ram_enable, n_ram_enable;
    logic [4:0] r_bank_low,   n_bank_low;
    logic [1:0] r_bank_high,  n_bank_high;
    logic       r_bank_mode,  n_bank_mode;
    logic       r_boot_active, n_boot_active;

    // Result register
    logic          r_res_valid;
    cbc_pkg::t_res r_res, n_res;
    logic          r_ram_sel, n_ram_sel;

    logic              w_accept;
    logic [4:0]        w_bank_lo5;
    logic [6:0]        w_bank_raw;
    logic [6:0]        w_bank;
    logic [1:0]        w_ram_bank;
    logic [cbc_pkg::ROM_AW-1:0] w_rom_sw;
    cbc_pkg::t_ram_req w_ram_req;
    logic [7:0]        w_ram_rdata;

    // Every access completes in one pass, so a new one is always taken.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Configuration only lands while no access is taken or in flight.
    assign o_cfg_ready = !r_res_valid && !w_accept;

    // Switchable ROM bank: zero counts as one, high bits only in ROM mode,
    // then trim to the bank count of the size code; bank one while banking is off.
    assign w_bank_lo5 = (r_bank_low == 5'd0) ? 5'd1 : r_bank_low;
    assign w_bank_raw = {(r_bank_mode ? 2'b00 : r_bank_high), w_bank_lo5};

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            w_bank[i] = w_bank_raw[i] && (3'(i) <= r_rom_size);
        end
        if (!r_banking_en) begin
            w_bank = 7'd1;
        end
    end

    assign w_rom_sw   = {w_bank, i_cmd.address[13:0]};
    assign w_ram_bank = r_bank_mode ? r_bank_high : 2'b00;

    // Decode one access: update bank registers, build the result, drive RAM.
    always_comb begin
        n_ram_enable  = r_ram_enable;
        n_bank_low    = r_bank_low;
        n_bank_high   = r_bank_high;
        n_bank_mode   = r_bank_mode;
        n_boot_active = r_boot_active;
        n_ram_sel     = 1'b0;

        n_res.source      = cbc_pkg::SRC_NONE;
        n_res.rom_address = '0;
        n_res.read_data   = '0;

        w_ram_req.re    = 1'b0;
        w_ram_req.we    = 1'b0;
        w_ram_req.index = {w_ram_bank, i_cmd.address[12:0]};
        w_ram_req.wdata = i_cmd.write_data;

        if (w_accept) begin
            if (i_cmd.mode == cbc_pkg::MODE_WRITE) begin
                unique case (i_cmd.address[15:13])
                    cbc_pkg::REG_RAM_EN: begin
                        n_ram_enable = (i_cmd.write_data[3:0] == cbc_pkg::RAM_EN_KEY);
                    end
                    cbc_pkg::REG_BANK_LOW: begin
                        n_bank_low = (i_cmd.write_data[4:0] == 5'd0) ?
                                     5'd1 : i_cmd.write_data[4:0];
                    end
                    cbc_pkg::REG_BANK_HIGH: begin
                        n_bank_high = i_cmd.write_data[1:0];
                    end
                    cbc_pkg::REG_BANK_MODE: begin
                        n_bank_mode = i_cmd.write_data[0];
                    end
                    cbc_pkg::REG_CART_RAM: begin
                        // Drop the write while RAM is disabled.
                        w_ram_req.we = r_ram_enable;
                    end
                    default: begin
                        // Unmapped region: no effect.
                    end
                endcase
            end else begin
                priority if (i_cmd.address[15:14] == cbc_pkg::RD_FIXED_ROM) begin
                    if (r_boot_active && r_boot_en &&
                        i_cmd.address[15:cbc_pkg::BOOT_AW] == '0) begin
                        n_res.source      = cbc_pkg::SRC_BOOT;
                        n_res.rom_address = cbc_pkg::ROM_AW'(
                                            i_cmd.address[cbc_pkg::BOOT_AW-1:0]);
                    end else begin
                        // Reading the cartridge entry point unmaps the boot ROM.
                        if (i_cmd.address == cbc_pkg::BOOT_EXIT) begin
                            n_boot_active = 1'b0;
                        end
                        n_res.source      = cbc_pkg::SRC_ROM;
                        n_res.rom_address = cbc_pkg::ROM_AW'(i_cmd.address) & ROM_MASK;
                    end
                end else if (i_cmd.address[15:14] == cbc_pkg::RD_SWITCH_ROM) begin
                    n_res.source      = cbc_pkg::SRC_ROM;
                    n_res.rom_address = w_rom_sw & ROM_MASK;
                end else if (i_cmd.address[15:13] == cbc_pkg::REG_CART_RAM) begin
                    if (r_ram_enable) begin
                        n_res.source = cbc_pkg::SRC_RAM;
                        w_ram_req.re = 1'b1;
                        n_ram_sel    = 1'b1;
                    end else begin
                        n_res.source    = cbc_pkg::SRC_RAMOFF;
                        n_res.read_data = cbc_pkg::RAMOFF_DATA;
                    end
                end else begin
                    // Unmapped read: leave the default result.
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_banking_en  <= 1'b1;
            r_rom_size    <= 3'd0;
            r_boot_en     <= 1'b1;
            r_ram_enable  <= 1'b0;
            r_bank_low    <= 5'd0;
            r_bank_high   <= 2'd0;
            r_bank_mode   <= 1'b0;
            r_boot_active <= 1'b1;
            r_res_valid   <= 1'b0;
            r_ram_sel     <= 1'b0;
        end else begin
            r_ram_enable  <= n_ram_enable;
            r_bank_low    <= n_bank_low;
            r_bank_high   <= n_bank_high;
            r_bank_mode   <= n_bank_mode;
            r_boot_active <= n_boot_active;
            r_res_valid   <= w_accept;
            r_ram_sel     <= n_ram_sel;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    cbc_pkg::CFG_BANKING_EN: r_banking_en <= i_cfg_data[0];
                    cbc_pkg::CFG_ROM_SIZE:   r_rom_size   <= i_cfg_data;
                    cbc_pkg::CFG_BOOT_EN:    r_boot_en    <= i_cfg_data[0];
                    default: begin
                        // Index beyond the register list: ignore the word.
                    end
                endcase
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    cbc_cart_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_cart_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

    // Take RAM read data straight from the memory's output register.
    always_comb begin
        o_res = r_res;
        if (r_ram_sel) begin
            o_res.read_data = w_ram_rdata;
        end
    end

    assign o_res_valid = r_res_valid;

endmodule

### rtl/core/cbc_cart_ram.sv
// ============================================================================
// cbc_cart_ram
// Banked cartridge RAM: one port, read data registered.
// ============================================================================
module cbc_cart_ram #(
    parameter int unsigned RAM_BYTES = 32768
) (
    input  logic              i_clk,
    input  cbc_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata
);

    localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

    logic [7:0]        r_mem [RAM_BYTES];
    logic [7:0]        r_rdata;
    logic [RAM_AW-1:0] w_index;

    assign w_index = i_req.index[RAM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[w_index] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[w_index];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cbc_checker.sv
// ============================================================================
// cbc_checker
// Port-level checks on the cartridge bank controller, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module cbc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input cbc_pkg::t_cmd i_cmd,
    input logic          o_res_valid,
    input cbc_pkg::t_res o_res
);

    // Each accepted access gives exactly one result, in the next cycle.
    `CBC_ASSERT_NEXT(a_res_follows, i_clk, i_rst_n, start && !busy, o_res_valid)
    `CBC_ASSERT_NEXT(a_no_extra_res, i_clk, i_rst_n, !(start && !busy), !o_res_valid)

    // Writes never report a mapped source.
    `CBC_ASSERT_NEXT(a_write_none, i_clk, i_rst_n,
        start && !busy && i_cmd.mode == cbc_pkg::MODE_WRITE,
        o_res.source == cbc_pkg::SRC_NONE)

    // Boot ROM addresses stay inside the boot image.
    `CBC_ASSERT_IMPLY(a_boot_range, i_clk, i_rst_n,
        o_res_valid && o_res.source == cbc_pkg::SRC_BOOT,
        o_res.rom_address[cbc_pkg::ROM_AW-1:cbc_pkg::BOOT_AW] == '0)

    // Disabled RAM always reads as all ones.
    `CBC_ASSERT_IMPLY(a_ramoff_data, i_clk, i_rst_n,
        o_res_valid && o_res.source == cbc_pkg::SRC_RAMOFF,
        o_res.read_data == cbc_pkg::RAMOFF_DATA)

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (.*);
